>>> src/mzad_pkg.sv
// ----------------------------------------------------------------------------
// mzad_pkg: shared codes for the max z-score anomaly detector
// Command codes, register indexes and fixed widths used by the RTL and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mzad_pkg;

	// command field (tuser on the input stream); code 3 is ignored
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_LOAD   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic CFG_SAMPLE_LEN = 1'b0;
	localparam logic CFG_THRESHOLD  = 1'b1;

	// quotient width of the divider and saturation value of the score
	localparam int          QBITS     = 32;
	localparam logic [31:0] SCORE_MAX = 32'hFFFF_FFFF;

	// feature position counter holds at this value
	localparam logic [6:0] POSITION_LIMIT = 7'd127;

endpackage : mzad_pkg

`default_nettype wire

>>> src/mzad_table.sv
// ----------------------------------------------------------------------------
// mzad_table: baseline table memory
// One mean and one spread per feature, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mzad_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [63:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [63:0]   rdata
);

	logic [63:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : mzad_table

`default_nettype wire

>>> src/mzad_div.sv
// ----------------------------------------------------------------------------
// mzad_div: restoring divider with saturating 32-bit quotient
// Dividend is {hi, lo}; hi at or above the divisor saturates the quotient.
// One quotient bit per cycle after the start cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mzad_div
	import mzad_pkg::*;
#(
	parameter int HW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [HW-1:0] dvd_hi,
	input  wire logic [31:0]   dvd_lo,
	input  wire logic [31:0]   divisor,
	output logic               done,
	output logic      [31:0]   quot
);

	localparam int CW = $clog2(QBITS + 1);
	localparam logic [CW-1:0] QBITS_C = CW'(QBITS);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [31:0]   rem_q;
	logic [31:0]   lo_q;
	logic [31:0]   div_q;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          ge;

	assign trial = {rem_q, lo_q[31]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				div_q <= divisor;
				if (32'(dvd_hi) >= divisor) begin
					quot <= SCORE_MAX;
					done <= 1'b1;
				end else begin
					rem_q  <= 32'(dvd_hi);
					lo_q   <= dvd_lo;
					cnt_q  <= QBITS_C;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= ge ? diff[31:0] : trial[31:0];
				lo_q  <= {lo_q[30:0], 1'b0};
				quot  <= {quot[30:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule : mzad_div

`default_nettype wire

>>> src/max_zscore_anomaly_detector_top.sv
// ----------------------------------------------------------------------------
// max_zscore_anomaly_detector_top: max absolute z-score anomaly detector
//
//   channel | handshake          | payload
//   s_*     | s_tvalid/s_tready  | tdata value,spread,entry_index; tuser command; tlast
//   m_*     | m_tvalid/m_tready  | tdata score; tuser anomaly
//   cfg_*   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A sample feature in range passes through transfer with table read, operand
// setup, divider start, quotient bits, divider done and update; features past
// the table end go from the transfer to the update. Load, clear and unknown
// commands end with the transfer. The restoring divider produces one quotient
// bit per cycle, or saturates at once. No clearing pass after reset. A final
// feature waits in the update step while the previous result has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module max_zscore_anomaly_detector_top
	import mzad_pkg::*;
#(
	parameter int MAX_FEATURES = 64,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // value[31:0], spread[63:32], entry_index[69:64]
	input  wire logic [1:0]  s_tuser,   // command[1:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // score[31:0]
	output logic             m_tuser,   // anomaly[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int IW = ($clog2(MAX_FEATURES + 1) > 8) ? $clog2(MAX_FEATURES + 1) : 8;
	localparam int HW = FRAC_BITS + 1;
	localparam int FLOOR_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam logic signed [31:0] SPREAD_FLOOR = 32'((FLOOR_RAW < 1) ? 1 : FLOOR_RAW);
	localparam logic [IW-1:0] MAXF_W = IW'(MAX_FEATURES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_START,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [6:0]    count_q;
	logic signed [31:0] threshold_q;
	logic          model_valid_q;
	logic [31:0]   run_max_q;
	logic [6:0]    pos_q;
	logic          last_q;
	logic          scored_q;
	logic signed [31:0] value_q;
	logic [32:0]   mag_q;
	logic [31:0]   divisor_q;

	logic          s_xfer;
	logic          is_sample;
	logic [IW-1:0] pos_ext;
	logic [IW-1:0] entry_ext;
	logic          pos_in_range;
	logic          tbl_we;
	logic          tbl_re;
	logic [63:0]   tbl_rdata;
	logic signed [31:0] mean;
	logic signed [31:0] spread;
	logic signed [32:0] diff;
	logic [32:0]   mag;
	logic [31:0]   divisor;
	logic [HW+31:0] dividend;
	logic          div_done;
	logic [31:0]   div_quot;
	logic [31:0]   z_eff;
	logic [31:0]   new_max;
	logic [6:0]    next_count;
	logic          model_ok;
	logic [31:0]   score;
	logic          emit;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_xfer    = s_tvalid && s_tready;
	assign is_sample = (s_tuser == CMD_SAMPLE);

	assign pos_ext      = IW'(pos_q);
	assign entry_ext    = IW'(s_tdata[69:64]);
	assign pos_in_range = pos_ext < MAXF_W;
	assign tbl_we       = s_xfer && (s_tuser == CMD_LOAD) && (entry_ext < MAXF_W);
	assign tbl_re       = s_xfer && is_sample && pos_in_range;

	mzad_table #(
		.DEPTH (MAX_FEATURES),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_ext[AW-1:0]),
		.wdata (s_tdata[63:0]),
		.re    (tbl_re),
		.raddr (pos_ext[AW-1:0]),
		.rdata (tbl_rdata)
	);

	// operand setup from the table entry
	assign mean    = tbl_rdata[31:0];
	assign spread  = tbl_rdata[63:32];
	assign diff    = {value_q[31], value_q} - {mean[31], mean};
	assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
	assign divisor = (spread < SPREAD_FLOOR) ? SPREAD_FLOOR : spread;

	assign dividend = {mag_q, {FRAC_BITS{1'b0}}};

	mzad_div #(
		.HW (HW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_START),
		.dvd_hi  (dividend[HW+31:32]),
		.dvd_lo  (dividend[31:0]),
		.divisor (divisor_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	// update step
	assign z_eff      = scored_q ? div_quot : '0;
	assign new_max    = (z_eff > run_max_q) ? z_eff : run_max_q;
	assign next_count = (pos_q < POSITION_LIMIT) ? (pos_q + 7'd1) : POSITION_LIMIT;
	assign model_ok   = model_valid_q && (next_count == count_q) && (IW'(count_q) <= MAXF_W);
	assign score      = model_ok ? new_max : '0;
	assign emit       = (state_q == ST_FINISH) && last_q && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			threshold_q   <= '0;
			model_valid_q <= 1'b0;
			run_max_q     <= '0;
			pos_q         <= '0;
			m_tvalid      <= 1'b0;
		end else begin
			if (m_tready && !emit) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SAMPLE_LEN: count_q     <= cfg_data[6:0];
					CFG_THRESHOLD:  threshold_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						value_q  <= s_tdata[31:0];
						last_q   <= s_tlast;
						scored_q <= pos_in_range;
						case (s_tuser)
							CMD_SAMPLE: state_q <= pos_in_range ? ST_READ : ST_FINISH;
							CMD_LOAD: begin
								if (s_tlast) begin
									model_valid_q <= 1'b1;
								end
							end
							CMD_CLEAR: model_valid_q <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_READ: begin
					mag_q     <= mag;
					divisor_q <= divisor;
					state_q   <= ST_START;
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						run_max_q <= new_max;
						pos_q     <= next_count;
						state_q   <= ST_IDLE;
					end else if (emit) begin
						// hold until the previous result transfer completes
						m_tvalid  <= 1'b1;
						m_tdata   <= score;
						m_tuser   <= threshold_q[31] || (score > threshold_q[31:0]);
						run_max_q <= '0;
						pos_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : max_zscore_anomaly_detector_top

`default_nettype wire

>>> src/mzad_checker.sv
// ----------------------------------------------------------------------------
// mzad_checker: port-level checks for the anomaly detector
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mzad_checker
	import mzad_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// a sample transfer occupies the block for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_SAMPLE) |=> !s_tready)
	else $error("input accepted right after a sample transfer");

	// a new result only comes out of the busy sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
	else $error("result raised without sample processing");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
	else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
	else $error("result changed while stalled");

endmodule : mzad_checker

bind max_zscore_anomaly_detector_top mzad_checker u_mzad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
